// ===== sv/wall_column_texel_mapper_unit_macros.svh =====
// assertion helpers shared by the checker
`ifndef WALL_COLUMN_TEXEL_MAPPER_UNIT_MACROS_SVH
`define WALL_COLUMN_TEXEL_MAPPER_UNIT_MACROS_SVH

// property on a given clock, switched off while reset is low
`define WCTM_ASSERT_RST(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rstn) prop) else $error(msg);

// same, on the block's own clock and reset
`define WCTM_ASSERT(lbl, prop, msg) \
  `WCTM_ASSERT_RST(lbl, clk_i, rst_ni, prop, msg)

`endif

// ===== sv/wctm_pkg.sv =====
package wctm_pkg;

  localparam int SCREEN_MAX = 4096;
  localparam int TEX_MAX    = 1024;

  localparam logic [12:0] ScreenHeightRst = 13'd720;
  localparam logic [12:0] ScreenWidthRst  = 13'd1280;

  // magnitude of (2*row - height + wall) * tex_height, and its quotient by 2*wall
  localparam int NumW = 27;
  localparam int DenW = 17;
  localparam int QuoW = 26;
  localparam int ThW  = 11;
  localparam int TxW  = 10;

  // cycles from the start transfer edge to the edge that takes the result
  localparam int LATENCY = NumW + QuoW + 6;

  typedef enum logic [2:0] {
    FACE_NORTH = 3'd0,
    FACE_SOUTH = 3'd1,
    FACE_WEST  = 3'd2,
    FACE_EAST  = 3'd3,
    FACE_DOOR  = 3'd4
  } face_e;

  typedef enum logic [1:0] {
    CFG_SCREEN_HEIGHT = 2'd0,
    CFG_SCREEN_WIDTH  = 2'd1
  } cfg_idx_e;

  typedef struct packed {
    logic           vis;
    logic [2:0]     tsel;
    logic           bad;
    logic           wh_nz;
    logic           mirror;
    logic           neg;
    logic [ThW-1:0] tw;
    logic [ThW-1:0] th;
    logic [TxW-1:0] tx;
  } side_t;

  typedef struct packed {
    side_t           sd;
    logic [NumW-1:0] num;
    logic [DenW-1:0] rem;
    logic [NumW-1:0] quo;
    logic [DenW-1:0] den;
  } div_t;

  typedef struct packed {
    side_t           sd;
    logic [QuoW-1:0] num;
    logic [ThW-2:0]  rem;
  } mod_t;

  function automatic logic [12:0] clamp_screen(logic [12:0] v);
    return (v > 13'(SCREEN_MAX)) ? 13'(SCREEN_MAX) : v;
  endfunction

  function automatic logic [ThW-1:0] clamp_tex(logic [ThW-1:0] v);
    logic [ThW-1:0] r;
    r = v;
    if (v == '0) begin
      r = ThW'(1);
    end else if (v > ThW'(TEX_MAX)) begin
      r = ThW'(TEX_MAX);
    end
    return r;
  endfunction

  // one restoring step: one quotient bit
  function automatic div_t div_step(div_t x);
    logic [DenW:0] trial;
    logic          ge;
    div_t          y;
    trial = {x.rem, x.num[NumW-1]};
    ge    = trial >= {1'b0, x.den};
    y     = x;
    y.num = {x.num[NumW-2:0], 1'b0};
    y.rem = ge ? DenW'(trial - {1'b0, x.den}) : trial[DenW-1:0];
    y.quo = {x.quo[NumW-2:0], ge};
    return y;
  endfunction

  // one remainder step against the texture height
  function automatic mod_t mod_step(mod_t x);
    logic [ThW-1:0] trial;
    logic           ge;
    mod_t           y;
    trial = {x.rem, x.num[QuoW-1]};
    ge    = trial >= x.sd.th;
    y     = x;
    y.num = {x.num[QuoW-2:0], 1'b0};
    y.rem = ge ? (ThW-1)'(trial - x.sd.th) : trial[ThW-2:0];
    return y;
  endfunction

endpackage

// ===== sv/wall_column_texel_mapper_unit.sv =====
// stages: each item goes through 3 setup, 1 texel column, 27 divider, 1 mirror,
// 26 remainder and 1 output stage, and done_o marks its result from the output stage
// throughput: one item per cycle, busy is always low; the divider and remainder
// pipelines take one bit per stage so a new item enters every cycle
// reset: rst_ni low clears all valid bits and sets screen size to 720 x 1280
// results cannot be held off by the receiver
module wall_column_texel_mapper_unit import wctm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               start,
  output logic               busy,
  input  logic               cfg_we_i,
  input  logic [1:0]         cfg_idx_i,
  input  logic [12:0]        cfg_wdata_i,
  input  logic [11:0]        row_i,
  input  logic [11:0]        column_i,
  input  logic [15:0]        wall_height_i,
  input  logic [27:0]        ray_distance_i,
  input  logic signed [17:0] ray_dir_x_i,
  input  logic signed [17:0] ray_dir_y_i,
  input  logic [27:0]        player_x_i,
  input  logic [27:0]        player_y_i,
  input  logic [2:0]         face_i,
  input  logic               hit_axis_i,
  input  logic [10:0]        tex_width_i,
  input  logic [10:0]        tex_height_i,
  output logic               done_o,
  output logic               visible_o,
  output logic [2:0]         texture_select_o,
  output logic [9:0]         texel_x_o,
  output logic [9:0]         texel_y_o
);

  logic [12:0] screen_height_q, screen_width_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      screen_height_q <= ScreenHeightRst;
      screen_width_q  <= ScreenWidthRst;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        CFG_SCREEN_HEIGHT: screen_height_q <= cfg_wdata_i;
        CFG_SCREEN_WIDTH:  screen_width_q  <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  assign busy = 1'b0;

  // ---------------- stage 1: span, selection, flags
  logic [12:0]        hov, wov;
  logic [11:0]        mid, span_lo;
  logic [14:0]        half;
  logic [15:0]        span_hi, span_end;
  logic               use_y;
  side_t              s1_side_d;
  logic               s1_vld_q;
  side_t              s1_side_q;
  logic [15:0]        s1_pos_q;
  logic [27:0]        s1_dist_q;
  logic signed [17:0] s1_dir_q;
  logic signed [17:0] s1_e_q;
  logic [15:0]        s1_wh_q;

  always_comb begin
    hov      = clamp_screen(screen_height_q);
    wov      = clamp_screen(screen_width_q);
    mid      = hov[12:1];
    half     = wall_height_i[15:1];
    span_lo  = ({3'b0, mid} > half) ? mid - half[11:0] : 12'd0;
    span_hi  = {4'b0, mid} + {1'b0, half};
    span_end = (span_hi > {3'b0, hov}) ? {3'b0, hov} : span_hi;
    if (face_i == FACE_DOOR) begin
      use_y = !hit_axis_i;
    end else begin
      use_y = (face_i == FACE_WEST) || (face_i == FACE_EAST);
    end
    s1_side_d.vis    = (wall_height_i != '0) && ({1'b0, column_i} < wov)
                       && (row_i >= span_lo) && ({4'b0, row_i} < span_end);
    s1_side_d.tsel   = face_i;
    s1_side_d.bad    = face_i > FACE_DOOR;
    s1_side_d.wh_nz  = wall_height_i != '0;
    s1_side_d.mirror = ((face_i == FACE_NORTH) && ray_dir_y_i[17])
                    || ((face_i == FACE_SOUTH) && !ray_dir_y_i[17] && (ray_dir_y_i != '0))
                    || ((face_i == FACE_WEST) && ray_dir_x_i[17])
                    || ((face_i == FACE_EAST) && !ray_dir_x_i[17] && (ray_dir_x_i != '0));
    s1_side_d.neg    = 1'b0;
    s1_side_d.tw     = clamp_tex(tex_width_i);
    s1_side_d.th     = clamp_tex(tex_height_i);
    s1_side_d.tx     = '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_vld_q <= 1'b0;
    end else begin
      s1_vld_q <= start && !busy;
    end
  end

  always_ff @(posedge clk_i) begin
    if (start && !busy) begin
      s1_side_q <= s1_side_d;
      s1_pos_q  <= use_y ? player_y_i[15:0] : player_x_i[15:0];
      s1_dist_q <= ray_distance_i;
      s1_dir_q  <= use_y ? ray_dir_y_i : ray_dir_x_i;
      // 2*row - height + wall, twice the row offset from the top of the wall span
      s1_e_q    <= $signed({5'b0, row_i, 1'b0} + {2'b0, wall_height_i} - {5'b0, hov});
      s1_wh_q   <= wall_height_i;
    end
  end

  // ---------------- stage 2: the two products
  logic signed [46:0] pdir;
  logic signed [29:0] pn;
  logic               s2_vld_q;
  side_t              s2_side_q;
  logic [15:0]        s2_pos_q;
  logic [31:0]        s2_pdir_q;
  logic signed [29:0] s2_pn_q;
  logic [15:0]        s2_wh_q;

  assign pdir = $signed({1'b0, s1_dist_q}) * s1_dir_q;
  assign pn   = s1_e_q * $signed({1'b0, s1_side_q.th});

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_vld_q <= 1'b0;
    end else begin
      s2_vld_q <= s1_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s1_vld_q) begin
      s2_side_q <= s1_side_q;
      s2_pos_q  <= s1_pos_q;
      s2_pdir_q <= pdir[31:0];
      s2_pn_q   <= pn;
      s2_wh_q   <= s1_wh_q;
    end
  end

  // ---------------- stage 3: hit fraction, dividend magnitude
  logic [31:0]     hit_sum;
  logic [29:0]     pn_abs;
  side_t           s3_side_d;
  logic            s3_vld_q;
  side_t           s3_side_q;
  logic [15:0]     s3_frac_q;
  logic [NumW-1:0] s3_mag_q;
  logic [DenW-1:0] s3_den_q;

  assign hit_sum = {s2_pos_q, 16'b0} + s2_pdir_q;
  assign pn_abs  = s2_pn_q[29] ? 30'(-s2_pn_q) : 30'(s2_pn_q);

  always_comb begin
    s3_side_d     = s2_side_q;
    s3_side_d.neg = s2_pn_q[29];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s3_vld_q <= 1'b0;
    end else begin
      s3_vld_q <= s2_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s2_vld_q) begin
      s3_side_q     <= s3_side_d;
      s3_frac_q     <= hit_sum[31:16];
      s3_mag_q      <= pn_abs[NumW-1:0];
      s3_den_q      <= {s2_wh_q, 1'b0};
    end
  end

  // ---------------- stage 4: texel column, then divider steps
  logic [26:0] tx_prod;
  div_t        dv_d0;
  div_t        dv_q     [NumW+1];
  logic        dv_vld_q [NumW+1];

  assign tx_prod = s3_frac_q * s3_side_q.tw;

  always_comb begin
    dv_d0       = '0;
    dv_d0.sd    = s3_side_q;
    dv_d0.sd.tx = tx_prod[25:16];
    dv_d0.num   = s3_mag_q;
    dv_d0.den   = s3_den_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dv_vld_q[0] <= 1'b0;
    end else begin
      dv_vld_q[0] <= s3_vld_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s3_vld_q) begin
      dv_q[0] <= dv_d0;
    end
  end

  for (genvar k = 1; k <= NumW; k++) begin : g_div
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        dv_vld_q[k] <= 1'b0;
      end else begin
        dv_vld_q[k] <= dv_vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (dv_vld_q[k-1]) begin
        dv_q[k] <= div_step(dv_q[k-1]);
      end
    end
  end

  // ---------------- mirror, then remainder steps
  mod_t md_d0;
  mod_t md_q     [QuoW+1];
  logic md_vld_q [QuoW+1];

  always_comb begin
    md_d0     = '0;
    md_d0.sd  = dv_q[NumW].sd;
    md_d0.num = dv_q[NumW].quo[QuoW-1:0];
    if (dv_q[NumW].sd.mirror) begin
      md_d0.sd.tx = TxW'(dv_q[NumW].sd.tw - ThW'(1) - {1'b0, dv_q[NumW].sd.tx});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      md_vld_q[0] <= 1'b0;
    end else begin
      md_vld_q[0] <= dv_vld_q[NumW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (dv_vld_q[NumW]) begin
      md_q[0] <= md_d0;
    end
  end

  for (genvar k = 1; k <= QuoW; k++) begin : g_mod
    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        md_vld_q[k] <= 1'b0;
      end else begin
        md_vld_q[k] <= md_vld_q[k-1];
      end
    end

    always_ff @(posedge clk_i) begin
      if (md_vld_q[k-1]) begin
        md_q[k] <= mod_step(md_q[k-1]);
      end
    end
  end

  // ---------------- output register
  side_t          fin_sd;
  logic [ThW-2:0] fin_rem;
  logic [TxW-1:0] ty_d;
  logic           done_q, vis_q;
  logic [2:0]     tsel_q;
  logic [TxW-1:0] tx_q, ty_q;

  always_comb begin
    fin_sd  = md_q[QuoW].sd;
    fin_rem = md_q[QuoW].rem;
    ty_d    = fin_rem;
    if (!fin_sd.wh_nz) begin
      ty_d = '0;
    end else if (fin_sd.neg && (fin_rem != '0)) begin
      // negative quotient wraps into 0..h-1
      ty_d = TxW'(fin_sd.th - {1'b0, fin_rem});
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      done_q <= 1'b0;
    end else begin
      done_q <= md_vld_q[QuoW];
    end
  end

  always_ff @(posedge clk_i) begin
    if (md_vld_q[QuoW]) begin
      if (fin_sd.bad) begin
        vis_q  <= 1'b0;
        tsel_q <= '0;
        tx_q   <= '0;
        ty_q   <= '0;
      end else begin
        vis_q  <= fin_sd.vis;
        tsel_q <= fin_sd.tsel;
        tx_q   <= fin_sd.tx;
        ty_q   <= ty_d;
      end
    end
  end

  assign done_o           = done_q;
  assign visible_o        = vis_q;
  assign texture_select_o = tsel_q;
  assign texel_x_o        = tx_q;
  assign texel_y_o        = ty_q;

endmodule

// ===== sv/wctm_checker.sv =====
`include "wall_column_texel_mapper_unit_macros.svh"

module wctm_checker import wctm_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        start,
  input logic        busy,
  input logic [15:0] wall_height_i,
  input logic [2:0]  face_i,
  input logic        done_o,
  input logic        visible_o,
  input logic [2:0]  texture_select_o
);

  // every result goes back to a start transfer a fixed latency earlier
  `WCTM_ASSERT(a_done_has_start, done_o |-> $past(start && !busy, LATENCY), "result without start")

  // the face travels with its item through the whole pipe, faces above the door come out as north
  `WCTM_ASSERT(a_tsel_follows_face, done_o |-> (texture_select_o == (($past(face_i, LATENCY) > FACE_DOOR) ? FACE_NORTH : $past(face_i, LATENCY))), "texture select out of step")

  // a zero height wall never shows
  `WCTM_ASSERT(a_vis_needs_wall, (done_o && visible_o) |-> ($past(wall_height_i, LATENCY) != 16'd0), "visible with zero wall height")

endmodule

bind wall_column_texel_mapper_unit wctm_checker u_wctm_checker (.*);

// ===== verif/tb_wall_column_texel_mapper_unit.sv =====
module tb_wall_column_texel_mapper_unit;
  timeunit 1ns;
  timeprecision 1ps;
  import wctm_pkg::*;

  localparam int CYCLE_LIMIT = 200000;
  // indexes past the two screen registers, the block must ignore writes there
  localparam logic [1:0] CFG_SPARE_LO = 2'd2;
  localparam logic [1:0] CFG_SPARE_HI = 2'd3;
  localparam logic signed [17:0] DIR_POS = 18'sh0B505;
  localparam logic signed [17:0] DIR_NEG = -18'sh0B505;
  localparam logic signed [17:0] DIR_ONE = 18'sh10000;

  typedef struct {
    logic [11:0]        row;
    logic [11:0]        column;
    logic [15:0]        wall_height;
    logic [27:0]        ray_distance;
    logic signed [17:0] ray_dir_x;
    logic signed [17:0] ray_dir_y;
    logic [27:0]        player_x;
    logic [27:0]        player_y;
    logic [2:0]         face;
    logic               hit_axis;
    logic [10:0]        tex_width;
    logic [10:0]        tex_height;
  } pixel_t;

  typedef struct {
    logic       vis;
    logic [2:0] tsel;
    logic [9:0] tx;
    logic [9:0] ty;
  } texel_t;

  logic               clk_i;
  logic               rst_ni;
  logic               start;
  logic               busy;
  logic               cfg_we_i;
  logic [1:0]         cfg_idx_i;
  logic [12:0]        cfg_wdata_i;
  logic [11:0]        row_i;
  logic [11:0]        column_i;
  logic [15:0]        wall_height_i;
  logic [27:0]        ray_distance_i;
  logic signed [17:0] ray_dir_x_i;
  logic signed [17:0] ray_dir_y_i;
  logic [27:0]        player_x_i;
  logic [27:0]        player_y_i;
  logic [2:0]         face_i;
  logic               hit_axis_i;
  logic [10:0]        tex_width_i;
  logic [10:0]        tex_height_i;
  logic               done_o;
  logic               visible_o;
  logic [2:0]         texture_select_o;
  logic [9:0]         texel_x_o;
  logic [9:0]         texel_y_o;

  logic [12:0] scr_height;
  logic [12:0] scr_width;
  texel_t      texel_queue[$];
  int          n_pixels;
  int          n_checked;
  int          n_errors;
  int          n_cfg_writes;
  int          n_settings;
  int          cycle_count;

  wall_column_texel_mapper_unit dut (
    .clk_i            (clk_i),
    .rst_ni           (rst_ni),
    .start            (start),
    .busy             (busy),
    .cfg_we_i         (cfg_we_i),
    .cfg_idx_i        (cfg_idx_i),
    .cfg_wdata_i      (cfg_wdata_i),
    .row_i            (row_i),
    .column_i         (column_i),
    .wall_height_i    (wall_height_i),
    .ray_distance_i   (ray_distance_i),
    .ray_dir_x_i      (ray_dir_x_i),
    .ray_dir_y_i      (ray_dir_y_i),
    .player_x_i       (player_x_i),
    .player_y_i       (player_y_i),
    .face_i           (face_i),
    .hit_axis_i       (hit_axis_i),
    .tex_width_i      (tex_width_i),
    .tex_height_i     (tex_height_i),
    .done_o           (done_o),
    .visible_o        (visible_o),
    .texture_select_o (texture_select_o),
    .texel_x_o        (texel_x_o),
    .texel_y_o        (texel_y_o)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout with %0d results outstanding", $time, texel_queue.size());
      $display("tb_wall_column_texel_mapper_unit failed");
      $finish;
    end
  end

  function automatic longint screen_clamp(logic [12:0] v);
    return (v > SCREEN_MAX) ? longint'(SCREEN_MAX) : longint'(v);
  endfunction

  function automatic longint tex_clamp(logic [10:0] v);
    if (v == '0) return 1;
    return (v > TEX_MAX) ? longint'(TEX_MAX) : longint'(v);
  endfunction

  function automatic texel_t predict_texel(pixel_t p);
    texel_t r;
    longint hov, wov, tw, th, wh, row, col, span_lo, span_hi;
    longint dirx, diry, hit, tx, ty, d, q;
    logic   use_y, mirror;
    r = '{default: '0};
    if (p.face > FACE_DOOR) return r;
    hov  = screen_clamp(scr_height);
    wov  = screen_clamp(scr_width);
    tw   = tex_clamp(p.tex_width);
    th   = tex_clamp(p.tex_height);
    wh   = longint'(p.wall_height);
    row  = longint'(p.row);
    col  = longint'(p.column);
    dirx = longint'($signed(p.ray_dir_x));
    diry = longint'($signed(p.ray_dir_y));
    span_lo = hov / 2 - wh / 2;
    span_hi = hov / 2 + wh / 2;
    if (span_lo < 0) span_lo = 0;
    if (span_hi > hov) span_hi = hov;
    if (p.face == FACE_DOOR) use_y = !p.hit_axis;
    else use_y = (p.face == FACE_WEST) || (p.face == FACE_EAST);
    // exact Q32 hit coordinate, only the fractional Q16 bits matter
    if (use_y) hit = (longint'(p.player_y) <<< 16) + longint'(p.ray_distance) * diry;
    else hit = (longint'(p.player_x) <<< 16) + longint'(p.ray_distance) * dirx;
    tx = (longint'(hit[31:16]) * tw) >>> 16;
    mirror = (p.face == FACE_NORTH && diry < 0) || (p.face == FACE_SOUTH && diry > 0) ||
             (p.face == FACE_WEST && dirx < 0) || (p.face == FACE_EAST && dirx > 0);
    if (mirror) tx = tw - tx - 1;
    ty = 0;
    if (wh != 0) begin
      d  = row * 256 - hov * 128 + wh * 128;
      q  = ((d * th) / wh) / 256;
      ty = q % th;
      if (ty < 0) ty += th;
    end
    r.vis  = (wh != 0) && (col < wov) && (row >= span_lo) && (row < span_hi);
    r.tsel = p.face;
    r.tx   = tx[9:0];
    r.ty   = ty[9:0];
    return r;
  endfunction

  // mostly plausible pixels of a wall slice, some with raw field values
  function automatic pixel_t rand_pixel();
    pixel_t p;
    longint hov, wov, v;
    int     pick;
    hov  = screen_clamp(scr_height);
    wov  = screen_clamp(scr_width);
    pick = $urandom_range(0, 9);
    if (pick == 0) p.wall_height = '0;
    else if (pick == 1) p.wall_height = 16'($urandom);
    else p.wall_height = 16'($urandom_range(1, 2 * hov + 8));
    pick = $urandom_range(0, 9);
    if (pick < 2) begin
      p.row = 12'($urandom);
    end else if (pick < 4) begin
      // around the span edges
      v = hov / 2 + ($urandom_range(0, 1) ? longint'(p.wall_height / 2)
                                          : -longint'(p.wall_height / 2));
      v = v + $urandom_range(0, 2) - 1;
      p.row = v[11:0];
    end else begin
      p.row = 12'($urandom_range(0, (hov > 0) ? hov - 1 : 0));
    end
    if ($urandom_range(0, 3) == 0) p.column = 12'($urandom);
    else p.column = 12'($urandom_range(0, (wov > 0) ? wov - 1 : 0));
    if ($urandom_range(0, 3) == 0) p.ray_distance = 28'($urandom);
    else p.ray_distance = 28'($urandom_range(0, 40 << 16));
    if ($urandom_range(0, 7) == 0) p.ray_dir_x = 18'($urandom);
    else p.ray_dir_x = 18'($urandom_range(0, 131072) - 65536);
    if ($urandom_range(0, 7) == 0) p.ray_dir_y = 18'($urandom);
    else p.ray_dir_y = 18'($urandom_range(0, 131072) - 65536);
    p.player_x = 28'($urandom);
    p.player_y = 28'($urandom);
    if ($urandom_range(0, 15) < 14) p.face = 3'($urandom_range(0, int'(FACE_DOOR)));
    else p.face = 3'(int'(FACE_DOOR) + $urandom_range(1, 3));
    p.hit_axis = 1'($urandom);
    pick = $urandom_range(0, 9);
    if (pick == 0) p.tex_width = 11'($urandom);
    else if (pick < 6) p.tex_width = 11'(1) << $urandom_range(4, 10);
    else p.tex_width = 11'($urandom_range(1, TEX_MAX));
    pick = $urandom_range(0, 9);
    if (pick == 0) p.tex_height = 11'($urandom);
    else if (pick < 6) p.tex_height = 11'(1) << $urandom_range(4, 10);
    else p.tex_height = 11'($urandom_range(1, TEX_MAX));
    return p;
  endfunction

  function automatic pixel_t base_pixel();
    pixel_t p;
    p.row          = 12'd360;
    p.column       = 12'd100;
    p.wall_height  = 16'd200;
    p.ray_distance = 28'h0031234;
    p.ray_dir_x    = DIR_POS;
    p.ray_dir_y    = DIR_NEG;
    p.player_x     = 28'h0058000;
    p.player_y     = 28'h0074000;
    p.face         = FACE_NORTH;
    p.hit_axis     = 1'b0;
    p.tex_width    = 11'd64;
    p.tex_height   = 11'd64;
    return p;
  endfunction

  task automatic check_field(string name, logic [15:0] want_v, logic [15:0] got_v);
    if (want_v !== got_v) begin
      $display("%0t: %s mismatch, expected %0d actual %0d", $time, name, want_v, got_v);
      n_errors++;
    end
  endtask

  always @(posedge clk_i) begin
    texel_t want;
    if (rst_ni && done_o) begin
      if (texel_queue.size() == 0) begin
        $display("%0t: result with none expected, visible %0b select %0d x %0d y %0d",
                 $time, visible_o, texture_select_o, texel_x_o, texel_y_o);
        n_errors++;
      end else begin
        want = texel_queue.pop_front();
        check_field("visible", want.vis, visible_o);
        check_field("texture_select", want.tsel, texture_select_o);
        check_field("texel_x", want.tx, texel_x_o);
        check_field("texel_y", want.ty, texel_y_o);
        n_checked++;
      end
    end
  end

  // returns at the edge that takes the transfer, start left high
  task automatic send_pixel(pixel_t p, int idle_pct);
    while ($urandom_range(0, 99) < idle_pct) begin
      start <= 1'b0;
      @(posedge clk_i);
    end
    row_i          <= p.row;
    column_i       <= p.column;
    wall_height_i  <= p.wall_height;
    ray_distance_i <= p.ray_distance;
    ray_dir_x_i    <= p.ray_dir_x;
    ray_dir_y_i    <= p.ray_dir_y;
    player_x_i     <= p.player_x;
    player_y_i     <= p.player_y;
    face_i         <= p.face;
    hit_axis_i     <= p.hit_axis;
    tex_width_i    <= p.tex_width;
    tex_height_i   <= p.tex_height;
    start          <= 1'b1;
    do @(posedge clk_i); while (busy);
    texel_queue.push_back(predict_texel(p));
    n_pixels++;
  endtask

  task automatic wait_texels_drained();
    start <= 1'b0;
    while (texel_queue.size() != 0) @(posedge clk_i);
  endtask

  task automatic write_screen_reg(logic [1:0] idx, logic [12:0] val);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    if (idx == CFG_SCREEN_HEIGHT) scr_height = val;
    else if (idx == CFG_SCREEN_WIDTH) scr_width = val;
    cfg_we_i <= 1'b0;
    @(posedge clk_i);
    n_cfg_writes++;
  endtask

  task automatic set_screen(logic [12:0] h, logic [12:0] w);
    wait_texels_drained();
    write_screen_reg(CFG_SCREEN_HEIGHT, h);
    write_screen_reg(CFG_SCREEN_WIDTH, w);
    n_settings++;
  endtask

  task automatic run_random(int n, int idle_pct);
    for (int i = 0; i < n; i++) send_pixel(rand_pixel(), idle_pct);
  endtask

  // reset screen size, every face and mirror case, clamps and field extremes
  task automatic test_directed_cases();
    pixel_t p;
    n_settings++;
    for (int f = FACE_NORTH; f <= FACE_EAST; f++) begin
      p = base_pixel();
      p.face = 3'(f);
      send_pixel(p, 0);
      p.ray_dir_x = DIR_NEG;
      p.ray_dir_y = DIR_POS;
      send_pixel(p, 0);
    end
    p = base_pixel();
    p.ray_dir_y = '0;
    send_pixel(p, 0);
    p = base_pixel();
    p.face = FACE_DOOR;
    send_pixel(p, 0);
    p.hit_axis = 1'b1;
    send_pixel(p, 0);
    for (int f = int'(FACE_DOOR) + 1; f < 8; f++) begin
      p = base_pixel();
      p.face = 3'(f);
      send_pixel(p, 0);
    end
    p = base_pixel();
    p.wall_height = '0;
    send_pixel(p, 0);
    p = '{default: '0};
    send_pixel(p, 0);
    p = '{row: '1, column: '1, wall_height: '1, ray_distance: '1, ray_dir_x: 18'sh1FFFF,
          ray_dir_y: 18'sh20000, player_x: '1, player_y: '1, face: FACE_DOOR,
          hit_axis: 1'b1, tex_width: '1, tex_height: '1};
    send_pixel(p, 0);
    p = base_pixel();
    p.tex_width  = '0;
    p.tex_height = '0;
    send_pixel(p, 0);
    p.tex_width  = 11'(TEX_MAX + 1);
    p.tex_height = 11'(TEX_MAX);
    send_pixel(p, 0);
    // above, below and at both edges of the span, the row quotient goes negative above
    p = base_pixel();
    p.wall_height = 16'd100;
    p.row = '0;
    send_pixel(p, 0);
    p.row = 12'd719;
    send_pixel(p, 0);
    p.row = 12'd310;
    send_pixel(p, 0);
    p.row = 12'd410;
    send_pixel(p, 0);
    p = base_pixel();
    p.column = 12'd1279;
    send_pixel(p, 0);
    p.column = 12'd1280;
    send_pixel(p, 0);
    p = base_pixel();
    p.face = FACE_WEST;
    p.ray_dir_x = DIR_ONE;
    p.ray_dir_y = -DIR_ONE;
    send_pixel(p, 0);
  endtask

  task automatic test_streaming();
    set_screen(13'd480, 13'd640);
    run_random(420, 0);
  endtask

  task automatic test_sparse_sender();
    set_screen(13'(SCREEN_MAX), 13'(SCREEN_MAX));
    run_random(400, 88);
  endtask

  // pauses until every result is back halfway through
  task automatic test_mixed_idle_with_drain();
    set_screen(13'($urandom_range(1, SCREEN_MAX)), 13'($urandom_range(1, SCREEN_MAX)));
    run_random(150, 23);
    wait_texels_drained();
    run_random(150, 23);
  endtask

  task automatic test_screen_clamp_and_empty();
    set_screen('0, '1);
    run_random(130, 23);
    set_screen('1, '0);
    run_random(130, 0);
    set_screen(13'd1, 13'd1);
    run_random(60, 23);
  endtask

  task automatic test_spare_index();
    set_screen(13'd720, 13'd1280);
    write_screen_reg(CFG_SPARE_LO, '1);
    write_screen_reg(CFG_SPARE_HI, '0);
    run_random(100, 23);
  endtask

  initial begin
    rst_ni         <= 1'b0;
    start          <= 1'b0;
    cfg_we_i       <= 1'b0;
    cfg_idx_i      <= CFG_SCREEN_HEIGHT;
    cfg_wdata_i    <= '0;
    row_i          <= '0;
    column_i       <= '0;
    wall_height_i  <= '0;
    ray_distance_i <= '0;
    ray_dir_x_i    <= '0;
    ray_dir_y_i    <= '0;
    player_x_i     <= '0;
    player_y_i     <= '0;
    face_i         <= FACE_NORTH;
    hit_axis_i     <= 1'b0;
    tex_width_i    <= '0;
    tex_height_i   <= '0;
    scr_height      = ScreenHeightRst;
    scr_width       = ScreenWidthRst;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed_cases();
    test_streaming();
    test_sparse_sender();
    test_mixed_idle_with_drain();
    test_screen_clamp_and_empty();
    test_spare_index();

    wait_texels_drained();
    repeat (LATENCY + 4) @(posedge clk_i);
    $display("sent %0d pixels across %0d screen settings with %0d register writes",
             n_pixels, n_settings, n_cfg_writes);
    $display("checked %0d texel results, %0d mismatches", n_checked, n_errors);
    if (n_errors == 0) begin
      $display("tb_wall_column_texel_mapper_unit passed");
    end else begin
      $display("tb_wall_column_texel_mapper_unit failed");
    end
    $finish;
  end

endmodule
